>>> sv/srde_pkg.sv
// ----------------------------------------------------------------------------
// srde_pkg: shared definitions for the sorted-run distinct estimator
// Widths, register map, sequencer states and the saturating counter step.
// ----------------------------------------------------------------------------
`default_nettype none

package srde_pkg;

  // Field and counter widths
  localparam int unsigned COUNT_W = 24;
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned N_W     = 40;
  localparam int unsigned FIELD_W = 24;
  localparam int unsigned EST_W   = 40;

  // Serial multiplier: operands wide enough for n*d and for N
  localparam int unsigned MUL_W     = (2 * COUNT_W > N_W) ? 2 * COUNT_W : N_W;
  localparam int unsigned PROD_W    = 2 * MUL_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_W + 1);

  // Serial divider: numerator n*d*N, denominator N*(n-f1) + f1*n
  localparam int unsigned NUM_W     = 2 * COUNT_W + N_W;
  localparam int unsigned DEN_W     = N_W + COUNT_W + 1;
  localparam int unsigned DIV_CNT_W = $clog2(NUM_W + 1);

  // Configuration port
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 64;
  localparam logic        REG_TOTAL_ROWS = 1'b0;
  localparam logic [N_W-1:0] TOTAL_ROWS_RESET = N_W'(1);

  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [2:0] {
    S_ROWS,
    S_MUL_ND,
    S_MUL_NUM,
    S_MUL_DA,
    S_MUL_DB,
    S_DIV,
    S_ROUND,
    S_DONE
  } state_e;

  // Count up, stick at the top value
  function automatic count_t sat_inc(input count_t v);
    return (v == '1) ? v : count_t'(v + 1'b1);
  endfunction

endpackage

`default_nettype wire

>>> sv/sorted_run_distinct_estimator.sv
// ----------------------------------------------------------------------------
// sorted_run_distinct_estimator: Duj1 distinct-value estimate of a sorted sample
// Counts rows, distinct keys and singletons, then computes the rounded,
// clamped estimate n*d*N / (N*(n-f1) + f1*n) with serial arithmetic.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake                     | payload
//  ----------+-----+-------------------------------+--------------------------
//  s_axis    | in  | s_axis_tvalid_i/tready_o      | tdata: row_key, tlast: last_row
//  m_axis    | out | m_axis_tvalid_o/tready_i      | tdata: estimate, distinct,
//            |     |                               |        singletons, rows
//  apb       | in  | psel/penable/pwrite, pready=1 | total_rows at address 0
//
//  Rows are taken one per cycle. After the row marked last the input stalls
//  while four products of the serial multiplier and the serial divider run,
//  then while the quotient is rounded and the result is loaded into the
//  output register.
//  A result waiting on m_axis does not stop rows of the next sample; the next
//  result waits for the output register to drain. Reset clears all counters
//  and sets total_rows to 1; no clearing pass is needed.
//
`default_nettype none

module sorted_run_distinct_estimator import srde_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Sample rows
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [KEY_W-1:0]    s_axis_tdata_i,   // [63:0] row_key
  input  logic                s_axis_tlast_i,   // last_row
  // Estimate result
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [39:0] estimate, [63:40] distinct_seen, [87:64] singletons, [111:88] rows_seen
  output logic [EST_W+3*FIELD_W-1:0] m_axis_tdata_o,
  // Configuration
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [ADDR_W-1:0]   paddr_i,
  input  logic [DATA_W-1:0]   pwdata_i,
  output logic [DATA_W-1:0]   prdata_o,
  output logic                pready_o
);

  state_e state_q, state_d;
  logic   launch_q, launch_d;

  logic [N_W-1:0]   total_rows_q;
  logic [KEY_W-1:0] prev_key_q;
  count_t           run_q, dist_q, single_q, rows_q;
  count_t           run_d, dist_d, single_d, rows_d, f1_d;
  count_t           n_q, d_q, f1_q, many;

  logic [NUM_W-1:0] num_q, q_q;
  logic [DEN_W-1:0] den_q;
  logic [N_W-1:0]   est_next;
  logic             round_up, den_zero, q_lt_d, d_gt_n, q_gt_n;

  logic [EST_W-1:0]   out_est_q;
  logic [FIELD_W-1:0] out_dist_q, out_single_q, out_rows_q;
  logic               out_valid_q;

  logic row_acc, out_load, cfg_wr;

  logic              mul_start, mul_done;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_prod;

  logic             div_start, div_done;
  logic [NUM_W-1:0] div_quo;
  logic [DEN_W-1:0] div_rem;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && (paddr_i[3] == REG_TOTAL_ROWS);
  assign prdata_o = (paddr_i[3] == REG_TOTAL_ROWS) ? DATA_W'(total_rows_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_rows_q <= TOTAL_ROWS_RESET;
    end else if (cfg_wr) begin
      total_rows_q <= pwdata_i[N_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Run tracking for one row
  // --------------------------------------------------------------------------
  always_comb begin
    run_d    = run_q;
    dist_d   = dist_q;
    single_d = single_q;
    if (rows_q == '0) begin
      run_d  = count_t'(1);
      dist_d = count_t'(1);
    end else if (s_axis_tdata_i[KEY_W-1:0] != prev_key_q) begin
      single_d = (run_q == count_t'(1)) ? sat_inc(single_q) : single_q;
      dist_d   = sat_inc(dist_q);
      run_d    = count_t'(1);
    end else begin
      run_d = sat_inc(run_q);
    end
    rows_d = sat_inc(rows_q);
    // Close the final run for the singleton count
    f1_d   = (run_d == count_t'(1)) ? sat_inc(single_d) : single_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_key_q <= '0;
      run_q      <= '0;
      dist_q     <= '0;
      single_q   <= '0;
      rows_q     <= '0;
    end else if (row_acc) begin
      if (s_axis_tlast_i) begin
        prev_key_q <= '0;
        run_q      <= '0;
        dist_q     <= '0;
        single_q   <= '0;
        rows_q     <= '0;
      end else begin
        prev_key_q <= s_axis_tdata_i[KEY_W-1:0];
        run_q      <= run_d;
        dist_q     <= dist_d;
        single_q   <= single_d;
        rows_q     <= rows_d;
      end
    end
  end

  // Snapshot the sample totals for the estimate
  always_ff @(posedge clk_i) begin
    if (row_acc && s_axis_tlast_i) begin
      n_q  <= rows_d;
      d_q  <= dist_d;
      f1_q <= f1_d;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_ROWS:    if (row_acc && s_axis_tlast_i) state_d = S_MUL_ND;
      S_MUL_ND:  if (mul_done) state_d = S_MUL_NUM;
      S_MUL_NUM: if (mul_done) state_d = S_MUL_DA;
      S_MUL_DA:  if (mul_done) state_d = S_MUL_DB;
      S_MUL_DB:  if (mul_done) state_d = S_DIV;
      S_DIV:     if (div_done) state_d = S_ROUND;
      S_ROUND:   state_d = S_DONE;
      S_DONE:    if (out_load) state_d = S_ROWS;
      default:   state_d = S_ROWS;
    endcase
    launch_d = (state_d != state_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_ROWS;
      launch_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= launch_d;
    end
  end

  // Sequencer outputs and multiplier operand selection
  assign many = (f1_q > n_q) ? '0 : count_t'(n_q - f1_q);

  always_comb begin
    s_axis_tready_o = (state_q == S_ROWS);
    out_load        = (state_q == S_DONE) && (!out_valid_q || m_axis_tready_i);
    mul_start       = 1'b0;
    div_start       = launch_q && (state_q == S_DIV);
    mul_a           = '0;
    mul_b           = '0;
    unique case (state_q)
      S_MUL_ND: begin
        mul_start = launch_q;
        mul_a     = MUL_W'(n_q);
        mul_b     = MUL_W'(d_q);
      end
      S_MUL_NUM: begin
        mul_start = launch_q;
        mul_a     = mul_prod[MUL_W-1:0];
        mul_b     = MUL_W'(total_rows_q);
      end
      S_MUL_DA: begin
        mul_start = launch_q;
        mul_a     = MUL_W'(total_rows_q);
        mul_b     = MUL_W'(many);
      end
      S_MUL_DB: begin
        mul_start = launch_q;
        mul_a     = MUL_W'(f1_q);
        mul_b     = MUL_W'(n_q);
      end
      default: begin
      end
    endcase
  end

  assign row_acc = s_axis_tvalid_i && s_axis_tready_o;

  // --------------------------------------------------------------------------
  // Arithmetic units
  // --------------------------------------------------------------------------
  srde_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (mul_prod),
    .done_o  (mul_done)
  );

  srde_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .quo_o   (div_quo),
    .rem_o   (div_rem),
    .done_o  (div_done)
  );

  // Collect numerator and denominator, then round the quotient half up
  assign round_up = {div_rem, 1'b0} >= {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (mul_done && (state_q == S_MUL_NUM)) begin
      num_q <= mul_prod[NUM_W-1:0];
    end
    if (mul_done && (state_q == S_MUL_DA)) begin
      den_q <= mul_prod[DEN_W-1:0];
    end else if (mul_done && (state_q == S_MUL_DB)) begin
      den_q <= den_q + mul_prod[DEN_W-1:0];
    end
    if (state_q == S_ROUND) begin
      q_q <= div_quo + NUM_W'(round_up);
    end
  end

  // Clamp to [d, N]; the upper bound wins, and an empty divisor gives N
  assign den_zero = (den_q == '0);
  assign q_lt_d   = q_q < NUM_W'(d_q);
  assign d_gt_n   = NUM_W'(d_q) > NUM_W'(total_rows_q);
  assign q_gt_n   = q_q > NUM_W'(total_rows_q);
  assign est_next = (den_zero || (q_lt_d ? d_gt_n : q_gt_n)) ? total_rows_q :
                    (q_lt_d ? N_W'(d_q) : q_q[N_W-1:0]);

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_est_q    <= EST_W'(est_next);
      out_dist_q   <= FIELD_W'(d_q);
      out_single_q <= FIELD_W'(f1_q);
      out_rows_q   <= FIELD_W'(n_q);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_rows_q, out_single_q, out_dist_q, out_est_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_acc && s_axis_tlast_i) |=> !s_axis_tready_o)
    else $error("input still ready after the last row");

  a_count_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dist_q <= rows_q) && (single_q <= dist_q))
    else $error("counters out of order");

  a_mul_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_MUL_ND || state_q == S_MUL_NUM ||
                  state_q == S_MUL_DA || state_q == S_MUL_DB))
    else $error("product finished outside a multiply step");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == S_DONE))
    else $error("result raised without a finished estimate");
`endif

endmodule

`default_nettype wire

>>> sv/srde_mul.sv
// ----------------------------------------------------------------------------
// srde_mul: bit-serial shift-and-add multiplier
// Consumes one multiplier bit per cycle over the MUL_W multiplier bits.
// ----------------------------------------------------------------------------
`default_nettype none

module srde_mul import srde_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MUL_W-1:0]  a_i,
  input  logic [MUL_W-1:0]  b_i,
  output logic [PROD_W-1:0] prod_o,
  output logic              done_o
);

  logic [MUL_W-1:0]     a_q, b_q;
  logic [PROD_W-1:0]    acc_q;
  logic [MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [MUL_W:0]       sum;

  // Add the multiplicand into the upper half when the current bit is set
  assign sum = {1'b0, acc_q[PROD_W-1:MUL_W]} + (b_q[0] ? {1'b0, a_q} : '0);

  // Step counter and done pulse
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = MUL_CNT_W'(MUL_W);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == MUL_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Load operands, then shift the product right one bit per step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= {sum, acc_q[MUL_W-1:1]};
      b_q   <= b_q >> 1;
    end
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

>>> sv/srde_div.sv
// ----------------------------------------------------------------------------
// srde_div: bit-serial restoring divider
// Produces one quotient bit per cycle, NUM_W quotient bits per division.
// ----------------------------------------------------------------------------
`default_nettype none

module srde_div import srde_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o,
  output logic [DEN_W-1:0] rem_o,
  output logic             done_o
);

  logic [NUM_W-1:0]     num_q, quo_q;
  logic [DEN_W-1:0]     den_q, rem_q;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DEN_W:0]       trial, diff;
  logic                 fits;

  // Bring down the next numerator bit and try the subtraction
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  // Step counter and done pulse
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Shift numerator out, quotient in; keep the partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      quo_q <= {quo_q[NUM_W-2:0], fits};
      rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

>>> verif/tb_sorted_run_distinct_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_run_distinct_estimator: self-checking bench for the Duj1 estimator
// Streams sorted (and some unsorted) samples of row keys under several table
// row counts. Each row is tallied by an in-bench model of the run counters,
// and on the last row the exact, rounded and clamped estimate is queued. The
// monitor checks every result field against the oldest queued estimate.
// ----------------------------------------------------------------------------

module tb_sorted_run_distinct_estimator;
  import srde_pkg::*;

  localparam int unsigned RES_W         = EST_W + 3 * FIELD_W;
  localparam int          RANDOM_ROWS   = 260;
  localparam int          SETTLE_CYCLES = 400;
  localparam int          CYCLE_LIMIT   = 4_000_000;
  localparam int          PRINT_LIMIT   = 20;
  localparam logic [ADDR_W-1:0] TOTAL_ROWS_ADDR = ADDR_W'(8 * int'(REG_TOTAL_ROWS));

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             is_last;
  } row_t;

  typedef struct packed {
    logic [EST_W-1:0]   estimate;
    logic [FIELD_W-1:0] distinct;
    logic [FIELD_W-1:0] singles;
    logic [FIELD_W-1:0] rows;
  } estimate_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [KEY_W-1:0]   s_axis_tdata_i = '0;   // [63:0] row_key
  logic               s_axis_tlast_i = 1'b0; // last_row
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  // [39:0] estimate, [63:40] distinct_seen, [87:64] singletons, [111:88] rows_seen
  logic [RES_W-1:0]   m_axis_tdata_o;
  logic               psel_i = 1'b0;
  logic               penable_i = 1'b0;
  logic               pwrite_i = 1'b0;
  logic [ADDR_W-1:0]  paddr_i = '0;
  logic [DATA_W-1:0]  pwdata_i = '0;
  logic [DATA_W-1:0]  prdata_o;
  logic               pready_o;

  sorted_run_distinct_estimator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel_i          (psel_i),
    .penable_i       (penable_i),
    .pwrite_i        (pwrite_i),
    .paddr_i         (paddr_i),
    .pwdata_i        (pwdata_i),
    .prdata_o        (prdata_o),
    .pready_o        (pready_o)
  );

  always #1 clk_i = ~clk_i;

  // Pending rows, expected estimates and run statistics
  row_t        pending_rows[$];
  estimate_t   expected_estimates[$];
  int          mismatches = 0;
  int          rows_sent = 0;
  int          samples_sent = 0;
  int          results_checked = 0;
  int          row_settings = 1;
  int          cycles = 0;

  // Shadow of the table row count and of the run counters
  logic [N_W-1:0]     rows_total = TOTAL_ROWS_RESET;
  logic [KEY_W-1:0]   prev_key = '0;
  logic [COUNT_W-1:0] run_len = '0;
  logic [COUNT_W-1:0] distinct_cnt = '0;
  logic [COUNT_W-1:0] single_cnt = '0;
  logic [COUNT_W-1:0] row_cnt = '0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Exact n*d*N / (N*(n-f1) + f1*n), rounded half up, clamped to [d, N]
  function automatic logic [EST_W-1:0] duj1_estimate(input logic [COUNT_W-1:0] n,
                                                      input logic [COUNT_W-1:0] d,
                                                      input logic [COUNT_W-1:0] f1,
                                                      input logic [N_W-1:0] big_n);
    logic [127:0] num, den, quo, rem, many;
    many = (f1 > n) ? 128'd0 : 128'(n - f1);
    num  = 128'(n) * 128'(d) * 128'(big_n);
    den  = 128'(big_n) * many + 128'(f1) * 128'(n);
    if (den == 0) return EST_W'(big_n);
    quo = num / den;
    rem = num % den;
    if ((rem << 1) >= den) quo = quo + 1;
    if (quo < 128'(d)) quo = 128'(d);
    if (quo > 128'(big_n)) quo = 128'(big_n);
    return EST_W'(quo);
  endfunction

  // Advance the run counters by one row; queue the estimate on the last row
  task automatic tally_row(input row_t r);
    logic [COUNT_W-1:0] f1;
    if (row_cnt == 0) begin
      distinct_cnt = 1;
      run_len = 1;
    end else if (r.key != prev_key) begin
      if (run_len == 1) single_cnt = bump(single_cnt);
      distinct_cnt = bump(distinct_cnt);
      run_len = 1;
    end else begin
      run_len = bump(run_len);
    end
    prev_key = r.key;
    row_cnt = bump(row_cnt);
    if (r.is_last) begin
      f1 = (run_len == 1) ? bump(single_cnt) : single_cnt;
      expected_estimates.push_back('{estimate: duj1_estimate(row_cnt, distinct_cnt, f1,
                                                             rows_total),
                                     distinct: FIELD_W'(distinct_cnt),
                                     singles:  FIELD_W'(f1),
                                     rows:     FIELD_W'(row_cnt)});
      prev_key = '0;
      run_len = '0;
      distinct_cnt = '0;
      single_cnt = '0;
      row_cnt = '0;
      samples_sent++;
    end
  endtask

  task automatic check_result(input logic [RES_W-1:0] data);
    estimate_t want;
    if (expected_estimates.size() == 0) begin
      report_mismatch($sformatf("result %h with no estimate pending", data));
      return;
    end
    want = expected_estimates.pop_front();
    results_checked++;
    if (data[EST_W-1:0] !== want.estimate)
      report_mismatch($sformatf("estimate %0d, want %0d", data[EST_W-1:0], want.estimate));
    if (data[EST_W +: FIELD_W] !== want.distinct)
      report_mismatch($sformatf("distinct_seen %0d, want %0d",
                                data[EST_W +: FIELD_W], want.distinct));
    if (data[EST_W+FIELD_W +: FIELD_W] !== want.singles)
      report_mismatch($sformatf("singletons %0d, want %0d",
                                data[EST_W+FIELD_W +: FIELD_W], want.singles));
    if (data[EST_W+2*FIELD_W +: FIELD_W] !== want.rows)
      report_mismatch($sformatf("rows_seen %0d, want %0d",
                                data[EST_W+2*FIELD_W +: FIELD_W], want.rows));
  endtask

  // Row driver: bursts of random length separated by random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        tally_row(pending_rows[0]);
        void'(pending_rows.pop_front());
        rows_sent++;
      end
      // Hold a stalled request, else present the next row or idle
      if (!(s_axis_tvalid_i && !s_axis_tready_o)) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_rows.size() != 0) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= pending_rows[0].key;
          s_axis_tlast_i  <= pending_rows[0].is_last;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: ready follows a rotating mask, reloaded whenever its position wraps
  logic [31:0] stall_mask = '1;
  logic [4:0]  stall_pos = '0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) check_result(m_axis_tdata_o);
      if (stall_pos == 0) begin
        case ($urandom_range(0, 4))
          0, 1:    stall_mask = '1;
          2:       stall_mask = 32'h1;
          default: stall_mask = $urandom | 32'h1;
        endcase
      end
      m_axis_tready_i <= stall_mask[stall_pos];
      stall_pos = stall_pos + 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_row(input logic [KEY_W-1:0] key, input logic is_last);
    pending_rows.push_back('{key: key, is_last: is_last});
  endtask

  // Queue one sample; repeat_pct is the chance a row repeats the previous key
  task automatic queue_sample(input int len, input int repeat_pct, input bit ordered);
    logic [KEY_W-1:0] key;
    case ($urandom_range(0, 5))
      0:       key = '0;
      1:       key = '1 - KEY_W'($urandom_range(0, 2 * len));
      default: key = {$urandom, $urandom};
    endcase
    for (int i = 0; i < len; i++) begin
      if (i != 0 && $urandom_range(0, 99) >= repeat_pct) begin
        if (!ordered) key = {$urandom, $urandom};
        else if ($urandom_range(0, 3) == 0) key = key + ({$urandom, $urandom} >>
                                                         $urandom_range(0, 63));
        else key = key + KEY_W'($urandom_range(1, 3));
      end
      push_row(key, i == len - 1);
    end
  endtask

  // Mostly short sorted samples, a few long ones, one in ten unsorted
  task automatic queue_random(input int row_budget);
    int added, len, pct, shape;
    added = 0;
    while (added < row_budget) begin
      shape = $urandom_range(0, 9);
      len = (shape == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
      case ($urandom_range(0, 3))
        0:       pct = 0;
        1:       pct = 35;
        2:       pct = 75;
        default: pct = 100;
      endcase
      queue_sample(len, pct, shape != 9);
      added += len;
    end
  endtask

  // Drain all rows and results, then let the divider settle
  task automatic settle();
    while (pending_rows.size() != 0 || expected_estimates.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_total_rows(input logic [N_W-1:0] value);
    @(posedge clk_i);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= TOTAL_ROWS_ADDR;
    pwdata_i  <= DATA_W'(value);
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    rows_total = value;
    row_settings++;
    @(negedge clk_i);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset row count: one-row samples at both key extremes, a repeated run,
    // a zero key first, a trailing singleton
    push_row('0, 1'b1);
    push_row('1, 1'b1);
    push_row(KEY_W'(5), 1'b0);
    push_row(KEY_W'(5), 1'b1);
    push_row(KEY_W'(1), 1'b0);
    push_row(KEY_W'(2), 1'b0);
    push_row(KEY_W'(2), 1'b0);
    push_row(KEY_W'(3), 1'b1);
    queue_random(RANDOM_ROWS);
    settle();

    // Zero table rows: zero divisor without singletons, upper clamp with them
    write_total_rows('0);
    push_row(KEY_W'(7), 1'b0);
    push_row(KEY_W'(7), 1'b1);
    push_row(KEY_W'(9), 1'b0);
    push_row(KEY_W'(10), 1'b1);
    queue_random(RANDOM_ROWS);
    settle();

    // Largest table: all-singleton sample
    write_total_rows('1);
    for (int i = 0; i < 6; i++) push_row(KEY_W'(i), i == 5);
    queue_random(RANDOM_ROWS);
    settle();

    // Table smaller than the distinct count
    write_total_rows(N_W'(3));
    push_row(KEY_W'(10), 1'b0);
    push_row(KEY_W'(11), 1'b0);
    push_row(KEY_W'(11), 1'b0);
    push_row(KEY_W'(12), 1'b0);
    push_row(KEY_W'(13), 1'b0);
    push_row(KEY_W'(14), 1'b0);
    push_row(KEY_W'(15), 1'b1);
    queue_random(RANDOM_ROWS);
    settle();

    write_total_rows(N_W'({$urandom, $urandom}));
    queue_random(RANDOM_ROWS);
    settle();

    write_total_rows(N_W'($urandom_range(1, 1000)));
    queue_random(RANDOM_ROWS);
    settle();

    write_total_rows(N_W'(1));
    queue_random(RANDOM_ROWS);
    settle();

    $display("Streamed %0d rows in %0d samples under %0d table row counts",
             rows_sent, samples_sent, row_settings);
    $display("Checked %0d estimates, %0d field mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sorted_run_distinct_estimator.f
sv/srde_pkg.sv
sv/srde_mul.sv
sv/srde_div.sv
sv/sorted_run_distinct_estimator.sv
verif/tb_sorted_run_distinct_estimator.sv
